// File: sv/lsa_pkg.sv
// Package for the local sequence alignment block: sizes, operation and
// register codes, state type and score arithmetic types.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package lsa_pkg;

   // Capacity of each sequence and width of one score table cell.
   localparam int MAX_LEN     = 32;
   localparam int SCORE_WIDTH = 12;

   // Field widths fixed by the interface.
   localparam int SYM_W     = 8;
   localparam int OP_W      = 2;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int BEST_W    = 12;
   localparam int END_W     = 6;

   // Derived sizes.
   localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int TBL_AW     = 2 * IDX_W;
   localparam int TBL_DEPTH  = 1 << TBL_AW;
   localparam int PATH_DEPTH = 2 * MAX_LEN;
   localparam int PATH_W     = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam int CNT_W      = $clog2(PATH_DEPTH + 1);
   localparam int ARITH_W    = SCORE_WIDTH + 2;
   localparam int PATH_DW    = 2 * SYM_W + 2;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
   localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP      = 2'd2;

   // Configuration reset values.
   localparam logic signed [CFG_W-1:0] MATCH_RESET    = 8'sd2;
   localparam logic signed [CFG_W-1:0] MISMATCH_RESET = -8'sd1;
   localparam logic signed [CFG_W-1:0] GAP_RESET      = -8'sd2;

   typedef logic [SCORE_WIDTH-1:0]    score_type;
   typedef logic signed [ARITH_W-1:0] arith_type;

   localparam arith_type SCORE_MAX = arith_type'((1 << SCORE_WIDTH) - 1);

   // One column of the aligned output as kept in the path buffer.
   typedef struct packed {
      logic [SYM_W-1:0] a_symbol;
      logic             a_gap;
      logic [SYM_W-1:0] b_symbol;
      logic             b_gap;
   } path_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_CMP,
      ST_TB_START,
      ST_TB_CHK,
      ST_TB_RD_U,
      ST_TB_RD_L,
      ST_TB_DEC,
      ST_OUT_START,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_EMPTY
   } lsa_state_type;

endpackage

// File: sv/lsa_if.sv
// Handshake interfaces of the local sequence alignment block: request,
// response and register write channels.
// Depends on lsa_pkg for field widths.
interface lsa_req_if;
   logic                         valid;
   logic                         ready;
   logic [lsa_pkg::OP_W-1:0]     operation;
   logic [lsa_pkg::SYM_W-1:0]    symbol;

   modport source (output valid, output operation, output symbol, input ready);
   modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface lsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lsa_pkg::SYM_W-1:0]    a_symbol;
   logic                         a_gap;
   logic [lsa_pkg::SYM_W-1:0]    b_symbol;
   logic                         b_gap;
   logic [lsa_pkg::BEST_W-1:0]   best_score;
   logic [lsa_pkg::END_W-1:0]    end_row;
   logic [lsa_pkg::END_W-1:0]    end_col;
   logic                         empty_res;
   logic                         overflow;
   logic                         last;

   modport source (output valid, output a_symbol, output a_gap, output b_symbol,
                   output b_gap, output best_score, output end_row, output end_col,
                   output empty_res, output overflow, output last, input ready);
   modport sink   (input valid, input a_symbol, input a_gap, input b_symbol,
                   input b_gap, input best_score, input end_row, input end_col,
                   input empty_res, input overflow, input last, output ready);
endinterface

interface lsa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lsa_pkg::CSR_IDX_W-1:0]   index;
   logic [lsa_pkg::CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/lsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/local_sequence_alignment.sv
// Top level of the local sequence alignment block (Smith-Waterman, linear gap).
// Depends on lsa_pkg, the interfaces in lsa_if.sv and the RAM in lsa_ram.sv.
//
//   Channel  | Direction | Carries
//   ---------+-----------+------------------------------------------------
//   req_bus  | in        | operation (append A, append B, run), symbol
//   rsp_bus  | out       | aligned column, best score, end cell, flags
//   csr_bus  | in        | register index and data (match, mismatch, gap)
//
// A run fills the score table one cell at a time, traces the path back from the
// best cell and then gives one response per column of the alignment, or a single
// response flagged empty for an empty one. Every cell and every traceback step
// reads the score table through the single read port of its RAM.
// Reset is synchronous and clears lengths, flags, registers and the sequencer.
// A stalled response holds the output register; the block takes a new request
// as soon as the last response of a run sits in that register.
module local_sequence_alignment (
   input logic        clock,
   input logic        reset,
   lsa_req_if.sink    req_bus,
   lsa_rsp_if.source  rsp_bus,
   lsa_csr_if.sink    csr_bus
);

   // Sequencer and control state.
   lsa_pkg::lsa_state_type state_ff, state_in;
   logic [lsa_pkg::LEN_W-1:0] len_a_ff, len_a_in;
   logic [lsa_pkg::LEN_W-1:0] len_b_ff, len_b_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [lsa_pkg::CFG_W-1:0] match_ff, match_in;
   logic signed [lsa_pkg::CFG_W-1:0] mismatch_ff, mismatch_in;
   logic signed [lsa_pkg::CFG_W-1:0] gap_ff, gap_in;

   // Datapath registers.
   logic [lsa_pkg::LEN_W-1:0] i_ff, i_in;
   logic [lsa_pkg::LEN_W-1:0] j_ff, j_in;
   lsa_pkg::score_type diag_ff, diag_in;
   lsa_pkg::score_type left_ff, left_in;
   lsa_pkg::score_type best_ff, best_in;
   logic [lsa_pkg::LEN_W-1:0] bi_ff, bi_in;
   logic [lsa_pkg::LEN_W-1:0] bj_ff, bj_in;
   lsa_pkg::score_type c_ff, c_in;
   lsa_pkg::score_type d_ff, d_in;
   lsa_pkg::score_type u_ff, u_in;
   logic [lsa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [lsa_pkg::PATH_W-1:0] k_ff, k_in;

   // Response payload registers.
   lsa_pkg::path_entry_type out_col_ff, out_col_in;
   logic [lsa_pkg::BEST_W-1:0] out_best_ff, out_best_in;
   logic [lsa_pkg::END_W-1:0] out_row_ff, out_row_in;
   logic [lsa_pkg::END_W-1:0] out_col_idx_ff, out_col_idx_in;
   logic out_empty_ff, out_empty_in;
   logic out_ovf_ff, out_ovf_in;
   logic out_last_ff, out_last_in;

   // RAM ports.
   logic seq_a_we, seq_b_we, tbl_we, path_we;
   logic [lsa_pkg::IDX_W-1:0] seq_waddr;
   logic [lsa_pkg::SYM_W-1:0] seq_a_rdata, seq_b_rdata;
   logic [lsa_pkg::TBL_AW-1:0] tbl_waddr, tbl_raddr;
   lsa_pkg::score_type tbl_wdata, tbl_rdata;
   lsa_pkg::path_entry_type path_wdata, path_rdata;

   // Address helpers and the shared cell unit.
   logic [lsa_pkg::LEN_W-1:0] im1, im2, jm1, jm2;
   logic [lsa_pkg::CNT_W-1:0] cnt_m1;
   logic i_is1, j_is1, out_free, finish;
   lsa_pkg::arith_type pair_sc, gap_sc;
   lsa_pkg::arith_type cand_diag, cand_left, cand_up, cell_max;
   lsa_pkg::score_type up_score, cell_val, tb_left;
   lsa_pkg::arith_type c_ext;
   logic tb_diag_hit, tb_up_hit, tb_left_hit;

   function automatic lsa_pkg::arith_type to_arith(lsa_pkg::score_type x);
      return $signed({{(lsa_pkg::ARITH_W - lsa_pkg::SCORE_WIDTH){1'b0}}, x});
   endfunction

   function automatic lsa_pkg::arith_type cfg_arith(logic signed [lsa_pkg::CFG_W-1:0] x);
      return $signed({{(lsa_pkg::ARITH_W - lsa_pkg::CFG_W){x[lsa_pkg::CFG_W-1]}}, x});
   endfunction

   // Storage: both sequences, the score table and the traceback path.
   lsa_ram #(.WIDTH(lsa_pkg::SYM_W), .DEPTH(lsa_pkg::MAX_LEN)) u_seq_a (
      .clock   (clock),
      .wr_en   (seq_a_we),
      .wr_addr (seq_waddr),
      .wr_data (req_bus.symbol),
      .rd_addr (im1[lsa_pkg::IDX_W-1:0]),
      .rd_data (seq_a_rdata)
   );

   lsa_ram #(.WIDTH(lsa_pkg::SYM_W), .DEPTH(lsa_pkg::MAX_LEN)) u_seq_b (
      .clock   (clock),
      .wr_en   (seq_b_we),
      .wr_addr (seq_waddr),
      .wr_data (req_bus.symbol),
      .rd_addr (jm1[lsa_pkg::IDX_W-1:0]),
      .rd_data (seq_b_rdata)
   );

   lsa_ram #(.WIDTH(lsa_pkg::SCORE_WIDTH), .DEPTH(lsa_pkg::TBL_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   lsa_ram #(.WIDTH(lsa_pkg::PATH_DW), .DEPTH(lsa_pkg::PATH_DEPTH)) u_path (
      .clock   (clock),
      .wr_en   (path_we),
      .wr_addr (cnt_ff[lsa_pkg::PATH_W-1:0]),
      .wr_data (path_wdata),
      .rd_addr (k_ff),
      .rd_data (path_rdata)
   );

   // Position helpers; row and column 0 of the table read as zero.
   assign im1    = i_ff - lsa_pkg::LEN_W'(1);
   assign im2    = i_ff - lsa_pkg::LEN_W'(2);
   assign jm1    = j_ff - lsa_pkg::LEN_W'(1);
   assign jm2    = j_ff - lsa_pkg::LEN_W'(2);
   assign cnt_m1 = cnt_ff - lsa_pkg::CNT_W'(1);
   assign i_is1  = (i_ff == lsa_pkg::LEN_W'(1));
   assign j_is1  = (j_ff == lsa_pkg::LEN_W'(1));

   // Shared cell unit: best of diagonal, both gaps and zero, saturated.
   always_comb begin
      pair_sc   = (seq_a_rdata == seq_b_rdata) ? cfg_arith(match_ff) : cfg_arith(mismatch_ff);
      gap_sc    = cfg_arith(gap_ff);
      up_score  = i_is1 ? '0 : tbl_rdata;
      cand_diag = to_arith(diag_ff) + pair_sc;
      cand_left = to_arith(left_ff) + gap_sc;
      cand_up   = to_arith(up_score) + gap_sc;
      cell_max  = cand_diag;
      if (cand_left > cell_max) begin
         cell_max = cand_left;
      end
      if (cand_up > cell_max) begin
         cell_max = cand_up;
      end
      if (cell_max < 0) begin
         cell_val = '0;
      end else if (cell_max > lsa_pkg::SCORE_MAX) begin
         cell_val = lsa_pkg::SCORE_MAX[lsa_pkg::SCORE_WIDTH-1:0];
      end else begin
         cell_val = cell_max[lsa_pkg::SCORE_WIDTH-1:0];
      end
   end

   // Traceback predecessor tests against the current cell.
   always_comb begin
      tb_left     = j_is1 ? '0 : tbl_rdata;
      c_ext       = to_arith(c_ff);
      tb_diag_hit = (c_ext == to_arith(d_ff) + pair_sc);
      tb_up_hit   = (c_ext == to_arith(u_ff) + gap_sc);
      tb_left_hit = (c_ext == to_arith(tb_left) + gap_sc);
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer: next state, register updates and RAM controls.
   always_comb begin
      state_in       = state_ff;
      len_a_in       = len_a_ff;
      len_b_in       = len_b_ff;
      dropped_in     = dropped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      match_in       = match_ff;
      mismatch_in    = mismatch_ff;
      gap_in         = gap_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      diag_in        = diag_ff;
      left_in        = left_ff;
      best_in        = best_ff;
      bi_in          = bi_ff;
      bj_in          = bj_ff;
      c_in           = c_ff;
      d_in           = d_ff;
      u_in           = u_ff;
      cnt_in         = cnt_ff;
      k_in           = k_ff;
      out_col_in     = out_col_ff;
      out_best_in    = out_best_ff;
      out_row_in     = out_row_ff;
      out_col_idx_in = out_col_idx_ff;
      out_empty_in   = out_empty_ff;
      out_ovf_in     = out_ovf_ff;
      out_last_in    = out_last_ff;
      seq_a_we       = 1'b0;
      seq_b_we       = 1'b0;
      seq_waddr      = '0;
      tbl_we         = 1'b0;
      tbl_waddr      = {im1[lsa_pkg::IDX_W-1:0], jm1[lsa_pkg::IDX_W-1:0]};
      tbl_wdata      = cell_val;
      tbl_raddr      = {im2[lsa_pkg::IDX_W-1:0], jm1[lsa_pkg::IDX_W-1:0]};
      path_we        = 1'b0;
      path_wdata     = '0;
      finish         = 1'b0;

      // Register writes are taken in any cycle.
      if (csr_bus.valid) begin
         case (csr_bus.index)
            lsa_pkg::CSR_MATCH:    match_in    = $signed(csr_bus.data);
            lsa_pkg::CSR_MISMATCH: mismatch_in = $signed(csr_bus.data);
            lsa_pkg::CSR_GAP:      gap_in      = $signed(csr_bus.data);
            default: ;
         endcase
      end

      case (state_ff)
         lsa_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               case (req_bus.operation)
                  lsa_pkg::OP_APPEND_A: begin
                     seq_waddr = len_a_ff[lsa_pkg::IDX_W-1:0];
                     if (len_a_ff < lsa_pkg::LEN_W'(lsa_pkg::MAX_LEN)) begin
                        seq_a_we = 1'b1;
                        len_a_in = len_a_ff + lsa_pkg::LEN_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  lsa_pkg::OP_APPEND_B: begin
                     seq_waddr = len_b_ff[lsa_pkg::IDX_W-1:0];
                     if (len_b_ff < lsa_pkg::LEN_W'(lsa_pkg::MAX_LEN)) begin
                        seq_b_we = 1'b1;
                        len_b_in = len_b_ff + lsa_pkg::LEN_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  lsa_pkg::OP_RUN: begin
                     i_in    = lsa_pkg::LEN_W'(1);
                     j_in    = lsa_pkg::LEN_W'(1);
                     diag_in = '0;
                     left_in = '0;
                     best_in = '0;
                     bi_in   = '0;
                     bj_in   = '0;
                     if (len_a_ff == '0 || len_b_ff == '0) begin
                        state_in = lsa_pkg::ST_TB_START;
                     end else begin
                        state_in = lsa_pkg::ST_FILL_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Fetch the cell above; symbols arrive on their own ports.
         lsa_pkg::ST_FILL_RD: begin
            state_in = lsa_pkg::ST_FILL_CMP;
         end

         // Score one cell, store it and track the last top score.
         lsa_pkg::ST_FILL_CMP: begin
            tbl_we  = 1'b1;
            diag_in = up_score;
            left_in = cell_val;
            if (cell_val >= best_ff) begin
               best_in = cell_val;
               bi_in   = i_ff;
               bj_in   = j_ff;
            end
            if (j_ff == len_b_ff) begin
               if (i_ff == len_a_ff) begin
                  state_in = lsa_pkg::ST_TB_START;
               end else begin
                  i_in     = i_ff + lsa_pkg::LEN_W'(1);
                  j_in     = lsa_pkg::LEN_W'(1);
                  diag_in  = '0;
                  left_in  = '0;
                  state_in = lsa_pkg::ST_FILL_RD;
               end
            end else begin
               j_in     = j_ff + lsa_pkg::LEN_W'(1);
               state_in = lsa_pkg::ST_FILL_RD;
            end
         end

         lsa_pkg::ST_TB_START: begin
            i_in     = bi_ff;
            j_in     = bj_ff;
            c_in     = best_ff;
            cnt_in   = '0;
            state_in = lsa_pkg::ST_TB_CHK;
         end

         // Stop at the border, at a zero cell or when the path is full.
         lsa_pkg::ST_TB_CHK: begin
            tbl_raddr = {im2[lsa_pkg::IDX_W-1:0], jm2[lsa_pkg::IDX_W-1:0]};
            if (i_ff == '0 || j_ff == '0 || c_ff == '0 ||
                cnt_ff == lsa_pkg::CNT_W'(lsa_pkg::PATH_DEPTH)) begin
               state_in = lsa_pkg::ST_OUT_START;
            end else begin
               state_in = lsa_pkg::ST_TB_RD_U;
            end
         end

         lsa_pkg::ST_TB_RD_U: begin
            d_in      = (i_is1 || j_is1) ? '0 : tbl_rdata;
            tbl_raddr = {im2[lsa_pkg::IDX_W-1:0], jm1[lsa_pkg::IDX_W-1:0]};
            state_in  = lsa_pkg::ST_TB_RD_L;
         end

         lsa_pkg::ST_TB_RD_L: begin
            u_in      = i_is1 ? '0 : tbl_rdata;
            tbl_raddr = {im1[lsa_pkg::IDX_W-1:0], jm2[lsa_pkg::IDX_W-1:0]};
            state_in  = lsa_pkg::ST_TB_DEC;
         end

         // Diagonal first, then a gap in B, then a gap in A.
         lsa_pkg::ST_TB_DEC: begin
            state_in = lsa_pkg::ST_TB_CHK;
            if (tb_diag_hit) begin
               path_we             = 1'b1;
               path_wdata.a_symbol = seq_a_rdata;
               path_wdata.b_symbol = seq_b_rdata;
               i_in                = im1;
               j_in                = jm1;
               c_in                = d_ff;
               cnt_in              = cnt_ff + lsa_pkg::CNT_W'(1);
            end else if (tb_up_hit) begin
               path_we             = 1'b1;
               path_wdata.a_symbol = seq_a_rdata;
               path_wdata.b_gap    = 1'b1;
               i_in                = im1;
               c_in                = u_ff;
               cnt_in              = cnt_ff + lsa_pkg::CNT_W'(1);
            end else if (tb_left_hit) begin
               path_we             = 1'b1;
               path_wdata.a_gap    = 1'b1;
               path_wdata.b_symbol = seq_b_rdata;
               j_in                = jm1;
               c_in                = tb_left;
               cnt_in              = cnt_ff + lsa_pkg::CNT_W'(1);
            end else begin
               state_in = lsa_pkg::ST_OUT_START;
            end
         end

         lsa_pkg::ST_OUT_START: begin
            k_in = cnt_m1[lsa_pkg::PATH_W-1:0];
            if (cnt_ff == '0) begin
               state_in = lsa_pkg::ST_OUT_EMPTY;
            end else begin
               state_in = lsa_pkg::ST_OUT_RD;
            end
         end

         lsa_pkg::ST_OUT_RD: begin
            state_in = lsa_pkg::ST_OUT_LD;
         end

         // Path was recorded from the end cell back; play it out reversed.
         lsa_pkg::ST_OUT_LD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_col_in     = path_rdata;
               out_best_in    = lsa_pkg::BEST_W'(best_ff);
               out_row_in     = lsa_pkg::END_W'(bi_ff);
               out_col_idx_in = lsa_pkg::END_W'(bj_ff);
               out_empty_in   = 1'b0;
               out_ovf_in     = dropped_ff;
               out_last_in    = (k_ff == '0);
               if (k_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  k_in     = k_ff - lsa_pkg::PATH_W'(1);
                  state_in = lsa_pkg::ST_OUT_RD;
               end
            end
         end

         lsa_pkg::ST_OUT_EMPTY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_col_in     = '0;
               out_best_in    = lsa_pkg::BEST_W'(best_ff);
               out_row_in     = lsa_pkg::END_W'(bi_ff);
               out_col_idx_in = lsa_pkg::END_W'(bj_ff);
               out_empty_in   = 1'b1;
               out_ovf_in     = dropped_ff;
               out_last_in    = 1'b1;
               finish         = 1'b1;
            end
         end

         default: begin
            state_in = lsa_pkg::ST_IDLE;
         end
      endcase

      // The run is over once its last response is registered.
      if (finish) begin
         len_a_in   = '0;
         len_b_in   = '0;
         dropped_in = 1'b0;
         state_in   = lsa_pkg::ST_IDLE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsa_pkg::ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         match_ff     <= lsa_pkg::MATCH_RESET;
         mismatch_ff  <= lsa_pkg::MISMATCH_RESET;
         gap_ff       <= lsa_pkg::GAP_RESET;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         match_ff     <= match_in;
         mismatch_ff  <= mismatch_in;
         gap_ff       <= gap_in;
      end
   end

   // Datapath and response payload registers.
   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      diag_ff        <= diag_in;
      left_ff        <= left_in;
      best_ff        <= best_in;
      bi_ff          <= bi_in;
      bj_ff          <= bj_in;
      c_ff           <= c_in;
      d_ff           <= d_in;
      u_ff           <= u_in;
      cnt_ff         <= cnt_in;
      k_ff           <= k_in;
      out_col_ff     <= out_col_in;
      out_best_ff    <= out_best_in;
      out_row_ff     <= out_row_in;
      out_col_idx_ff <= out_col_idx_in;
      out_empty_ff   <= out_empty_in;
      out_ovf_ff     <= out_ovf_in;
      out_last_ff    <= out_last_in;
   end

   // Ports.
   assign req_bus.ready      = (state_ff == lsa_pkg::ST_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.a_symbol   = out_col_ff.a_symbol;
   assign rsp_bus.a_gap      = out_col_ff.a_gap;
   assign rsp_bus.b_symbol   = out_col_ff.b_symbol;
   assign rsp_bus.b_gap      = out_col_ff.b_gap;
   assign rsp_bus.best_score = out_best_ff;
   assign rsp_bus.end_row    = out_row_ff;
   assign rsp_bus.end_col    = out_col_idx_ff;
   assign rsp_bus.empty_res  = out_empty_ff;
   assign rsp_bus.overflow   = out_ovf_ff;
   assign rsp_bus.last       = out_last_ff;

   // Sequence lengths never pass the capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_a_ff <= lsa_pkg::LEN_W'(lsa_pkg::MAX_LEN)) &&
      (len_b_ff <= lsa_pkg::LEN_W'(lsa_pkg::MAX_LEN)))
      else $error("sequence length beyond capacity");

   // A dropped append means one of the sequences is full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> (len_a_ff == lsa_pkg::LEN_W'(lsa_pkg::MAX_LEN) ||
                      len_b_ff == lsa_pkg::LEN_W'(lsa_pkg::MAX_LEN)))
      else $error("overflow flag set with room left");

   // An accepted run request starts the sequencer.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.operation == lsa_pkg::OP_RUN)
      |=> (state_ff != lsa_pkg::ST_IDLE))
      else $error("run request did not start the sequencer");

   // The traceback never records more columns than the path buffer holds.
   a_path_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lsa_pkg::ST_TB_CHK) |->
      (cnt_ff <= lsa_pkg::CNT_W'(lsa_pkg::PATH_DEPTH)))
      else $error("traceback path too long");

endmodule
